>>> design/lgtm_pkg.sv
// Shared types, constants and register codes for the luma gradient tone map.
package lgtm_pkg;

	// Luma weights, sum is 65536 so the level fits 8 bits after >> 16
	localparam logic [15:0] LUMA_WR = 16'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [15:0] LUMA_WB = 16'd7471;

	localparam int COLOR_W  = 24;
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int PROD_W   = 24;

	// Queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COLOR_W-1:0] FIRST_COLOR_RST  = 24'hFF0000;
	localparam logic [COLOR_W-1:0] SECOND_COLOR_RST = 24'h0000FF;
	localparam logic [COLOR_W-1:0] THIRD_COLOR_RST  = 24'hFFFF00;
	localparam logic               THREE_MODE_RST   = 1'b1;

	typedef enum logic [1:0] {
		CFG_FIRST_COLOR  = 2'd0,
		CFG_SECOND_COLOR = 2'd1,
		CFG_THIRD_COLOR  = 2'd2,
		CFG_THREE_MODE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} lgtm_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} lgtm_out_t;

	typedef struct packed {
		logic [COLOR_W-1:0] first_color;
		logic [COLOR_W-1:0] second_color;
		logic [COLOR_W-1:0] third_color;
		logic               three_color_mode;
	} lgtm_cfg_t;

	// Classified word: which gradient segment and the blend position
	typedef struct packed {
		logic              upper;
		logic [CHAN_W-1:0] t;
	} lgtm_cls_t;

endpackage

>>> design/lgtm_front.sv
// Front end: accepts pixels, computes luma and picks the gradient segment.
module lgtm_front import lgtm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lgtm_cfg_t cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  lgtm_in_t  in_data,
	output logic      push_valid,
	output lgtm_cls_t push_data,
	input  logic      push_ready
);

	logic              valid_s1;
	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_g_s1;
	logic [PROD_W-1:0] prod_b_s1;
	logic [PROD_W-1:0] luma_sum;
	logic [CHAN_W-1:0] luma;
	logic              accept;

	assign push_valid = valid_s1;
	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_r_s1 <= PROD_W'(in_data.in_red) * PROD_W'(LUMA_WR);
			prod_g_s1 <= PROD_W'(in_data.in_green) * PROD_W'(LUMA_WG);
			prod_b_s1 <= PROD_W'(in_data.in_blue) * PROD_W'(LUMA_WB);
		end
	end

	assign luma_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign luma     = luma_sum[PROD_W-1 -: CHAN_W];

	// t = L in two-color mode; lower half 2L, upper half 2L-255 = {L[6:0], 1}
	always_comb begin
		if (!cfg.three_color_mode) begin
			push_data.upper = 1'b0;
			push_data.t     = luma;
		end else if (!luma[CHAN_W-1]) begin
			push_data.upper = 1'b0;
			push_data.t     = {luma[CHAN_W-2:0], 1'b0};
		end else begin
			push_data.upper = 1'b1;
			push_data.t     = {luma[CHAN_W-2:0], 1'b1};
		end
	end

endmodule

>>> design/lgtm_queue.sv
// Short queue of classified words between front and back.
module lgtm_queue import lgtm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  lgtm_cls_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output lgtm_cls_t pop_data
);

	lgtm_cls_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/lgtm_back.sv
// Back end: blends the segment colors per channel and holds the result word.
module lgtm_back import lgtm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lgtm_cfg_t cfg,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  lgtm_cls_t pop_data,
	output logic      out_valid,
	input  logic      out_ready,
	output lgtm_out_t out_data
);

	logic [COLOR_W-1:0]  from_c;
	logic [COLOR_W-1:0]  to_c;
	logic [CHAN_W-1:0]   from_ch   [NUM_CHAN];
	logic [CHAN_W-1:0]   to_ch     [NUM_CHAN];
	logic [CHAN_W-1:0]   dmag      [NUM_CHAN];
	logic                neg       [NUM_CHAN];

	logic                valid_s1;
	logic [2*CHAN_W-1:0] mag_s1    [NUM_CHAN];
	logic                neg_s1    [NUM_CHAN];
	logic [CHAN_W-1:0]   from_s1   [NUM_CHAN];

	logic [2*CHAN_W:0]   div_sum   [NUM_CHAN];
	logic [CHAN_W-1:0]   quot      [NUM_CHAN];
	logic signed [CHAN_W+1:0] blend [NUM_CHAN];
	logic [CHAN_W-1:0]   res       [NUM_CHAN];

	logic                out_valid_q;
	lgtm_out_t           out_data_q;
	logic                adv_s2;
	logic                load_s1;

	assign adv_s2    = !out_valid_q || out_ready;
	assign pop_ready = !valid_s1 || adv_s2;
	assign load_s1   = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign from_c = pop_data.upper ? cfg.second_color : cfg.first_color;
	assign to_c   = pop_data.upper ? cfg.third_color  : cfg.second_color;

	// Split the difference into sign and magnitude so the product stays unsigned
	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			from_ch[k] = from_c[COLOR_W-1-CHAN_W*k -: CHAN_W];
			to_ch[k]   = to_c[COLOR_W-1-CHAN_W*k -: CHAN_W];
			neg[k]     = to_ch[k] < from_ch[k];
			dmag[k]    = neg[k] ? (from_ch[k] - to_ch[k]) : (to_ch[k] - from_ch[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			for (int k = 0; k < NUM_CHAN; k++) begin
				mag_s1[k]  <= (2*CHAN_W)'(dmag[k]) * (2*CHAN_W)'(pop_data.t);
				neg_s1[k]  <= neg[k];
				from_s1[k] <= from_ch[k];
			end
		end
	end

	// m / 255 = (m + (m >> 8) + 1) >> 8, exact for m below 65535
	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			div_sum[k] = {1'b0, mag_s1[k]} + (2*CHAN_W+1)'(mag_s1[k] >> CHAN_W) + 1'b1;
			quot[k]    = div_sum[k][2*CHAN_W-1:CHAN_W];
			if (neg_s1[k]) begin
				blend[k] = $signed({2'b00, from_s1[k]}) - $signed({2'b00, quot[k]});
			end else begin
				blend[k] = $signed({2'b00, from_s1[k]}) + $signed({2'b00, quot[k]});
			end
			if (blend[k] < 0) begin
				res[k] = '0;
			end else if (blend[k] > $signed((CHAN_W+2)'(255))) begin
				res[k] = '1;
			end else begin
				res[k] = blend[k][CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_data_q.out_red   <= res[0];
			out_data_q.out_green <= res[1];
			out_data_q.out_blue  <= res[2];
		end
	end

endmodule

>>> design/luma_gradient_tone_map.sv
// Top level of the luma gradient tone map: config registers, front, queue, back.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     in_data  (lgtm_in_t)
//   out       out_valid / out_ready   out_data (lgtm_out_t)
//   cfg       cfg_we                  cfg_index, cfg_wdata
//
// One pixel per clock sustained while out_ready is high; each word passes through
// the luma product, queue entry, blend product and output registers in that order.
// The queue holds 4 classified words, so the front keeps taking pixels for a while
// after the output stalls. arst_n clears all valid flags and loads the reset colors.
module luma_gradient_tone_map import lgtm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lgtm_in_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lgtm_out_t          out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [COLOR_W-1:0] cfg_wdata
);

	lgtm_cfg_t cfg_q;
	logic      push_valid;
	logic      push_ready;
	lgtm_cls_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	lgtm_cls_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_color      <= FIRST_COLOR_RST;
			cfg_q.second_color     <= SECOND_COLOR_RST;
			cfg_q.third_color      <= THIRD_COLOR_RST;
			cfg_q.three_color_mode <= THREE_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_COLOR:  cfg_q.first_color      <= cfg_wdata;
				CFG_SECOND_COLOR: cfg_q.second_color     <= cfg_wdata;
				CFG_THIRD_COLOR:  cfg_q.third_color      <= cfg_wdata;
				CFG_THREE_MODE:   cfg_q.three_color_mode <= cfg_wdata[0];
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	lgtm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	lgtm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lgtm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// Front refuses a pixel only when its stage is full and the queue is full
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (push_valid && !push_ready))
		else $error("input stalled without a full queue");

	// A full queue always has a word to hand to the back end
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> pop_valid)
		else $error("queue reports full and empty together");

	// A word leaving the queue while the output is free passes the blend product and output registers to the output
	a_pop_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready && !out_valid) |=> ##1 out_valid)
		else $error("popped word did not reach the output");
`endif

endmodule
